FILE: rtl/dst_pkg.sv
// dst_pkg: shared constants, request/status codes and inter-module structs
// for the device slot table. No dependencies.
package dst_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = 4;
  localparam int ID_W       = 32;
  localparam int WORD_W     = 64;
  localparam int QI_W       = 8;
  localparam int REQ_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int EVENT_W    = 2;
  localparam int OUT_SLOT_W = 3;
  localparam int WR_OP_W    = 2;

  localparam logic [REQ_W-1:0] REQ_CONNECT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DISCONNECT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_UPDATE     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUBLISH    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DISC_ALL   = 3'd4;
  localparam logic [REQ_W-1:0] REQ_NTH        = 3'd5;
  localparam logic [REQ_W-1:0] REQ_BY_SLOT    = 3'd6;
  localparam logic [REQ_W-1:0] REQ_FIND       = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_CONN = 2'd1;
  localparam logic [EVENT_W-1:0] EV_DISC = 2'd2;

  localparam logic [WR_OP_W-1:0] WR_CONNECT = 2'd0;
  localparam logic [WR_OP_W-1:0] WR_FREE    = 2'd1;
  localparam logic [WR_OP_W-1:0] WR_DESC    = 2'd2;
  localparam logic [WR_OP_W-1:0] WR_STATE   = 2'd3;

  // request fields broadcast to every cell
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   device_id;
    logic [WORD_W-1:0] payload;
    logic [QI_W-1:0]   query_index;
  } bcast_t;

  // table write command, acted on by the addressed cell
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [WR_OP_W-1:0] op;
  } wr_t;

  // search token passed cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              more;
    logic [SLOT_W-1:0] hit_slot;
    logic [ID_W-1:0]   hit_device;
    logic [WORD_W-1:0] hit_descriptor;
    logic [WORD_W-1:0] hit_state;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    logic [QI_W-1:0]   remaining;
  } token_t;

endpackage

FILE: rtl/dst_cell.sv
// dst_cell: one table slot plus its stage of the search token chain.
// Depends on dst_pkg.
module dst_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [dst_pkg::SLOT_W-1:0] idx,
  input  dst_pkg::bcast_t          bc,
  input  dst_pkg::wr_t             wr,
  input  dst_pkg::token_t          tok_in,
  output dst_pkg::token_t          tok_out
);
  import dst_pkg::*;

  logic              valid;
  logic [ID_W-1:0]   device;
  logic [WORD_W-1:0] descriptor;
  logic [WORD_W-1:0] state;
  logic              wr_here;
  logic              cand;
  token_t            tok_next;
  token_t            tok_q;

  assign wr_here = wr.en && (wr.slot == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      case (wr.op)
        WR_CONNECT: valid <= 1'b1;
        WR_FREE:    valid <= 1'b0;
        default:    valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      case (wr.op)
        WR_CONNECT: begin
          device     <= bc.device_id;
          descriptor <= bc.payload;
          state      <= '0;
        end
        WR_DESC:  descriptor <= bc.payload;
        WR_STATE: state <= bc.payload;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (bc.req_type)
      REQ_NTH:      cand = valid && (tok_in.remaining == '0);
      REQ_BY_SLOT:  cand = valid && (QI_W'(idx) == bc.query_index);
      REQ_DISC_ALL: cand = valid;
      default:      cand = valid && (device == bc.device_id);
    endcase
  end

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && cand) begin
      tok_next.hit            = 1'b1;
      tok_next.hit_slot       = idx;
      tok_next.hit_device     = device;
      tok_next.hit_descriptor = descriptor;
      tok_next.hit_state      = state;
    end
    if (tok_in.hit && valid) begin
      tok_next.more = 1'b1;
    end
    if (!tok_in.free_found && !valid) begin
      tok_next.free_found = 1'b1;
      tok_next.free_slot  = idx;
    end
    if (valid && !tok_in.hit && (tok_in.remaining != '0)) begin
      tok_next.remaining = tok_in.remaining - QI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_next;
    end
  end

  assign tok_out = tok_q;

endmodule

FILE: rtl/device_slot_table_core.sv
// device_slot_table_core: top level, request sequencer over a row of dst_cell slots.
// Flow: an accepted request walks a search token through the cells, one cell per cycle,
// then the decision registers the result; next request accepted after the result is taken.
// Disconnect-all: one token walk per emitted result.
// Reset: all slots empty, count zero, no result pending; slot contents are not cleared.
module device_slot_table_core
  import dst_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dst_pkg::REQ_W-1:0]    req_type,
  input  logic [dst_pkg::ID_W-1:0]     device_id,
  input  logic [dst_pkg::WORD_W-1:0]   payload,
  input  logic [dst_pkg::QI_W-1:0]     query_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dst_pkg::STATUS_W-1:0] status,
  output logic [dst_pkg::OUT_SLOT_W-1:0] slot,
  output logic [dst_pkg::EVENT_W-1:0]  event_res,
  output logic [dst_pkg::ID_W-1:0]     device_out,
  output logic [dst_pkg::WORD_W-1:0]   descriptor_out,
  output logic [dst_pkg::WORD_W-1:0]   state_out,
  output logic [dst_pkg::CNT_W-1:0]    connected_count,
  output logic                         last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       fsm;
  logic             start;
  logic [CNT_W-1:0] count;
  bcast_t           bc;
  wr_t              wr;
  token_t           tok [SLOT_COUNT+1];
  token_t           fin;
  logic             decide;

  logic                emit;
  logic                fail;
  logic [STATUS_W-1:0] fail_status;
  logic [STATUS_W-1:0] r_status;
  logic [SLOT_W-1:0]   r_slot;
  logic [EVENT_W-1:0]  r_event;
  logic [ID_W-1:0]     r_dev;
  logic [WORD_W-1:0]   r_desc;
  logic [WORD_W-1:0]   r_state;
  logic                r_last;
  logic [CNT_W-1:0]    count_next;

  assign in_ready = (fsm == S_IDLE);

  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = start;
    tok[0].remaining = bc.query_index;
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    dst_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (SLOT_W'(i)),
      .bc      (bc),
      .wr      (wr),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign fin    = tok[SLOT_COUNT];
  assign decide = (fsm == S_SCAN) && fin.valid;

  always_comb begin
    emit        = 1'b1;
    fail        = 1'b0;
    fail_status = ST_NOTFOUND;
    r_status    = ST_OK;
    r_slot      = fin.hit_slot;
    r_event     = EV_NONE;
    r_dev       = fin.hit_device;
    r_desc      = fin.hit_descriptor;
    r_state     = fin.hit_state;
    r_last      = 1'b1;
    count_next  = count;
    wr          = '0;
    wr.slot     = fin.hit_slot;
    case (bc.req_type)
      REQ_CONNECT: begin
        if (bc.device_id == '0) begin
          fail        = 1'b1;
          fail_status = ST_INVALID;
        end else if (fin.hit) begin
          fail        = 1'b1;
          fail_status = ST_DUP;
        end else if (!fin.free_found) begin
          fail        = 1'b1;
          fail_status = ST_FULL;
        end else begin
          r_slot     = fin.free_slot;
          r_dev      = bc.device_id;
          r_desc     = bc.payload;
          r_state    = '0;
          r_event    = EV_CONN;
          count_next = count + CNT_W'(1);
          wr.en      = 1'b1;
          wr.slot    = fin.free_slot;
          wr.op      = WR_CONNECT;
        end
      end
      REQ_DISCONNECT: begin
        fail       = !fin.hit;
        r_event    = EV_DISC;
        count_next = count - CNT_W'(1);
        wr.en      = 1'b1;
        wr.op      = WR_FREE;
      end
      REQ_UPDATE: begin
        fail   = !fin.hit;
        r_desc = bc.payload;
        wr.en  = 1'b1;
        wr.op  = WR_DESC;
      end
      REQ_PUBLISH: begin
        fail    = !fin.hit;
        r_state = bc.payload;
        wr.en   = 1'b1;
        wr.op   = WR_STATE;
      end
      REQ_DISC_ALL: begin
        emit       = fin.hit;
        r_event    = EV_DISC;
        r_last     = !fin.more;
        count_next = fin.hit ? (count - CNT_W'(1)) : count;
        wr.en      = fin.hit;
        wr.op      = WR_FREE;
      end
      default: begin
        fail = !fin.hit;
      end
    endcase
    if (fail) begin
      r_status   = fail_status;
      r_slot     = '0;
      r_event    = EV_NONE;
      r_dev      = '0;
      r_desc     = '0;
      r_state    = '0;
      r_last     = 1'b1;
      count_next = count;
      wr.en      = 1'b0;
    end
    wr.en = wr.en && decide;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      start     <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (fsm)
        S_IDLE: begin
          start <= in_valid;
          if (in_valid) begin
            bc.req_type    <= req_type;
            bc.device_id   <= device_id;
            bc.payload     <= payload;
            bc.query_index <= query_index;
            fsm            <= S_SCAN;
          end
        end
        S_SCAN: begin
          start <= 1'b0;
          if (fin.valid) begin
            count <= count_next;
            if (emit) begin
              out_valid       <= 1'b1;
              status          <= r_status;
              slot            <= OUT_SLOT_W'(r_slot);
              event_res       <= r_event;
              device_out      <= r_dev;
              descriptor_out  <= r_desc;
              state_out       <= r_state;
              connected_count <= count_next;
              last            <= r_last;
              fsm             <= S_OUT;
            end else begin
              fsm <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          start <= out_ready && (bc.req_type == REQ_DISC_ALL) && !last;
          if (out_ready) begin
            out_valid <= 1'b0;
            if ((bc.req_type == REQ_DISC_ALL) && !last) begin
              fsm <= S_SCAN;
            end else begin
              fsm <= S_IDLE;
            end
          end
        end
        default: begin
          start <= 1'b0;
          fsm   <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for device_slot_table_core. Keeps its own copy of the
// slot table, predicts every result at request accept and compares results in order.
// Depends on dst_pkg and device_slot_table_core.
module tb_top;
  import dst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int ID_POOL_N   = 12;
  localparam int RAND_PER_PHASE = 107;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   device_id;
    logic [WORD_W-1:0] payload;
    logic [QI_W-1:0]   query_index;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [EVENT_W-1:0]    event_res;
    logic [ID_W-1:0]       device;
    logic [WORD_W-1:0]     descriptor;
    logic [WORD_W-1:0]     state;
    logic [CNT_W-1:0]      count;
    logic                  last;
  } slot_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] req_type = '0;
  logic [ID_W-1:0] device_id = '0;
  logic [WORD_W-1:0] payload = '0;
  logic [QI_W-1:0] query_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [OUT_SLOT_W-1:0] slot;
  logic [EVENT_W-1:0] event_res;
  logic [ID_W-1:0] device_out;
  logic [WORD_W-1:0] descriptor_out;
  logic [WORD_W-1:0] state_out;
  logic [CNT_W-1:0] connected_count;
  logic last;

  device_slot_table_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .device_id(device_id), .payload(payload),
    .query_index(query_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot(slot), .event_res(event_res), .device_out(device_out),
    .descriptor_out(descriptor_out), .state_out(state_out),
    .connected_count(connected_count), .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow table
  logic              tbl_valid [SLOT_COUNT];
  logic [ID_W-1:0]   tbl_device [SLOT_COUNT];
  logic [WORD_W-1:0] tbl_desc [SLOT_COUNT];
  logic [WORD_W-1:0] tbl_state [SLOT_COUNT];
  int                tbl_count = 0;

  request_t     pending_requests[$];
  slot_report_t reports_due[$];
  logic [ID_W-1:0] id_pool [ID_POOL_N];

  int send_idle_pct = 18;
  int recv_idle_pct = 68;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int errors = 0;
  request_t drv_req;
  slot_report_t got;

  function automatic int slot_of_id(logic [ID_W-1:0] id);
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (tbl_valid[k] && tbl_device[k] == id) return k;
    end
    return -1;
  endfunction

  function automatic void report_failure(logic [STATUS_W-1:0] st);
    slot_report_t rep;
    rep = '0;
    rep.status = st;
    rep.count = CNT_W'(tbl_count);
    rep.last = 1'b1;
    reports_due.push_back(rep);
  endfunction

  function automatic void report_slot(int s, logic [EVENT_W-1:0] ev, logic is_last);
    slot_report_t rep;
    rep.status = ST_OK;
    rep.slot = OUT_SLOT_W'(s);
    rep.event_res = ev;
    rep.device = tbl_device[s];
    rep.descriptor = tbl_desc[s];
    rep.state = tbl_state[s];
    rep.count = CNT_W'(tbl_count);
    rep.last = is_last;
    reports_due.push_back(rep);
  endfunction

  function automatic void apply_request(request_t r);
    int hit;
    int free_s;
    int last_s;
    logic [QI_W-1:0] ord;
    hit = slot_of_id(r.device_id);
    case (r.req_type)
      REQ_CONNECT: begin
        free_s = -1;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
          if (!tbl_valid[k]) free_s = k;
        end
        if (r.device_id == '0) report_failure(ST_INVALID);
        else if (hit >= 0) report_failure(ST_DUP);
        else if (free_s < 0) report_failure(ST_FULL);
        else begin
          tbl_valid[free_s] = 1'b1;
          tbl_device[free_s] = r.device_id;
          tbl_desc[free_s] = r.payload;
          tbl_state[free_s] = '0;
          tbl_count++;
          report_slot(free_s, EV_CONN, 1'b1);
        end
      end
      REQ_DISCONNECT, REQ_FIND: begin
        if (hit < 0) report_failure(ST_NOTFOUND);
        else if (r.req_type == REQ_FIND) report_slot(hit, EV_NONE, 1'b1);
        else begin
          tbl_valid[hit] = 1'b0;
          tbl_count--;
          report_slot(hit, EV_DISC, 1'b1);
        end
      end
      REQ_UPDATE, REQ_PUBLISH: begin
        if (hit < 0) report_failure(ST_NOTFOUND);
        else begin
          if (r.req_type == REQ_UPDATE) tbl_desc[hit] = r.payload;
          else tbl_state[hit] = r.payload;
          report_slot(hit, EV_NONE, 1'b1);
        end
      end
      REQ_DISC_ALL: begin
        last_s = -1;
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (tbl_valid[k]) last_s = k;
        end
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (tbl_valid[k]) begin
            tbl_valid[k] = 1'b0;
            tbl_count--;
            report_slot(k, EV_DISC, k == last_s);
          end
        end
      end
      REQ_NTH: begin
        if (int'(r.query_index) >= tbl_count) report_failure(ST_NOTFOUND);
        else begin
          ord = r.query_index;
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (tbl_valid[k]) begin
              if (ord == '0) begin
                report_slot(k, EV_NONE, 1'b1);
                return;
              end
              ord--;
            end
          end
        end
      end
      default: begin
        if (int'(r.query_index) >= SLOT_COUNT || !tbl_valid[SLOT_W'(r.query_index)])
          report_failure(ST_NOTFOUND);
        else report_slot(int'(r.query_index), EV_NONE, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want_v,
                                      logic [WORD_W-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  function automatic void add_request(logic [REQ_W-1:0] rt, logic [ID_W-1:0] id,
                                      logic [WORD_W-1:0] pl, logic [QI_W-1:0] qi);
    pending_requests.push_back('{rt, id, pl, qi});
  endfunction

  function automatic void add_random_request();
    logic [REQ_W-1:0] rt;
    logic [ID_W-1:0] id;
    logic [QI_W-1:0] qi;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) rt = REQ_CONNECT;
    else if (pick < 45) rt = REQ_DISCONNECT;
    else if (pick < 55) rt = REQ_UPDATE;
    else if (pick < 65) rt = REQ_PUBLISH;
    else if (pick < 68) rt = REQ_DISC_ALL;
    else if (pick < 78) rt = REQ_NTH;
    else if (pick < 88) rt = REQ_BY_SLOT;
    else rt = REQ_FIND;
    pick = $urandom_range(19);
    if (pick == 0) id = '0;
    else if (pick == 1) id = $urandom;
    else id = id_pool[$urandom_range(ID_POOL_N - 1)];
    qi = ($urandom_range(9) == 0) ? QI_W'($urandom) : QI_W'($urandom_range(9));
    add_request(rt, id, {$urandom, $urandom}, qi);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request('{req_type, device_id, payload, query_index});
      end
      if (!in_valid || in_ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          req_type <= drv_req.req_type;
          device_id <= drv_req.device_id;
          payload <= drv_req.payload;
          query_index <= drv_req.query_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $error("unexpected result: status %0d slot %0d event %0d", status, slot, event_res);
          errors++;
        end else begin
          got = reports_due.pop_front();
          check_field("status", WORD_W'(got.status), WORD_W'(status));
          check_field("slot", WORD_W'(got.slot), WORD_W'(slot));
          check_field("event_res", WORD_W'(got.event_res), WORD_W'(event_res));
          check_field("device_out", WORD_W'(got.device), WORD_W'(device_out));
          check_field("descriptor_out", got.descriptor, descriptor_out);
          check_field("state_out", got.state, state_out);
          check_field("connected_count", WORD_W'(got.count), WORD_W'(connected_count));
          check_field("last", WORD_W'(got.last), WORD_W'(last));
        end
      end
      if (hold_seen != hold_reqs) begin
        hold_seen <= hold_reqs;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: cycles with work outstanding but no handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (in_valid || pending_requests.size() > 0 || reports_due.size() > 0) begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("device_slot_table_core: mismatch");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_requests.size() > 0 || in_valid || reports_due.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    for (int k = 0; k < SLOT_COUNT; k++) begin
      tbl_valid[k] = 1'b0;
      tbl_device[k] = '0;
      tbl_desc[k] = '0;
      tbl_state[k] = '0;
    end
    id_pool[0] = 32'h1;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < ID_POOL_N; k++) id_pool[k] = $urandom | 32'h1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, fill, full, queries at the edges, teardown
    add_request(REQ_CONNECT, '0, '1, '0);
    add_request(REQ_DISC_ALL, '0, '0, '0);
    add_request(REQ_NTH, '0, '0, '0);
    add_request(REQ_BY_SLOT, '0, '0, '0);
    add_request(REQ_FIND, '0, '0, '0);
    add_request(REQ_CONNECT, 32'h1, '0, '0);
    add_request(REQ_CONNECT, 32'hFFFF_FFFF, '1, '0);
    add_request(REQ_CONNECT, 32'h1, 64'h5A5A, '0);
    add_request(REQ_PUBLISH, 32'hFFFF_FFFF, '1, '0);
    add_request(REQ_UPDATE, 32'h1, 64'hA5A5_A5A5_A5A5_A5A5, '0);
    for (int k = 2; k < SLOT_COUNT; k++) add_request(REQ_CONNECT, k, {$urandom, $urandom}, '0);
    add_request(REQ_CONNECT, 32'h8000_0000, '0, '0);
    add_request(REQ_NTH, '0, '0, 8'd7);
    add_request(REQ_NTH, '0, '0, 8'd8);
    add_request(REQ_NTH, '0, '0, 8'd255);
    add_request(REQ_BY_SLOT, '0, '0, 8'd7);
    add_request(REQ_BY_SLOT, '0, '0, 8'd8);
    add_request(REQ_BY_SLOT, '0, '0, 8'd255);
    add_request(REQ_FIND, 32'hFFFF_FFFF, '0, '0);
    add_request(REQ_DISCONNECT, 32'h3, '0, '0);
    add_request(REQ_UPDATE, '0, '1, '0);
    add_request(REQ_PUBLISH, '0, '1, '0);
    add_request(REQ_DISCONNECT, 32'h3, '0, '0);
    add_request(REQ_CONNECT, 32'h9, 64'h1, '0);
    add_request(REQ_DISC_ALL, '0, '0, '0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 68;
        recv_idle_pct = 18;
        hold_reqs++;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < RAND_PER_PHASE; n++) add_random_request();
      drain();
    end

    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("device_slot_table_core: match");
    end else begin
      $display("device_slot_table_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dst_pkg.sv
rtl/dst_cell.sv
rtl/device_slot_table_core.sv
tb/tb_top.sv
